/* sv/int2a_pkg.sv */
// Shared types and constants for the integer to ASCII digit converter.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package int2a_pkg;

   // Format codes carried with each request
   localparam logic [1:0] OP_SIGNED_DEC   = 2'd0;
   localparam logic [1:0] OP_UNSIGNED_DEC = 2'd1;
   localparam logic [1:0] OP_SIGNED_HEX   = 2'd2;
   localparam logic [1:0] OP_UNSIGNED_HEX = 2'd3;

   // ASCII characters
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_F = 8'h66;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_SKIP,
      ST_EMIT
   } int2a_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic convert;
      logic emit_sign;
      logic skip_shift;
      logic emit_digit;
   } int2a_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic load_hex;
      logic load_neg;
      logic neg;
      logic top_zero;
      logic rem_one;
      logic step_last;
      logic slot_free;
   } int2a_status_type;

   // Map one digit (0 to 15) to its lower-case ASCII character
   function automatic logic [7:0] digit_to_ascii(input logic [3:0] digit);
      logic [7:0] ch;
      if (digit < 4'd10) begin
         ch = CHAR_ZERO + {4'd0, digit};
      end else begin
         ch = CHAR_LOW_A + {4'd0, digit - 4'd10};
      end
      return ch;
   endfunction

endpackage

/* sv/int2a_req_if.sv */
// Request channel: one word and its format code, valid/ready handshake.
// No dependencies.
interface int2a_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic [1:0]  operation;

   modport source (output valid, output value, output operation, input ready);
   modport sink   (input valid, input value, input operation, output ready);
endinterface

/* sv/int2a_rsp_if.sv */
// Response channel: one ASCII character per transfer, with last flag and count.
// No dependencies.
interface int2a_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;
   logic [3:0] char_count;

   modport source (output valid, output character, output last, output char_count,
                   input ready);
   modport sink   (input valid, input character, input last, input char_count,
                   output ready);
endinterface

/* sv/int2a_ctrl.sv */
// Sequencing state machine of the converter: load, convert, sign, skip, emit.
// Depends on int2a_pkg.
module int2a_ctrl
   import int2a_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  int2a_status_type status,
   output int2a_cmd_type    cmd
);

   int2a_state_type state_ff;
   int2a_state_type state_in;

   // Hold the current state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pick the next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!status.load_hex) begin
                  state_in = ST_CONVERT;
               end else if (status.load_neg) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_SKIP;
               end
            end
         end
         ST_CONVERT: begin
            if (status.step_last) begin
               state_in = status.neg ? ST_SIGN : ST_SKIP;
            end
         end
         ST_SIGN: begin
            if (status.slot_free) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!status.top_zero || status.rem_one) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.slot_free && status.rem_one) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Drive datapath commands and the request ready
   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CONVERT: cmd.convert    = 1'b1;
         ST_SIGN:    cmd.emit_sign  = status.slot_free;
         ST_SKIP:    cmd.skip_shift = status.top_zero && !status.rem_one;
         ST_EMIT:    cmd.emit_digit = status.slot_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* sv/int2a_datapath.sv */
// Datapath of the converter: magnitude, BCD shift-add-3 register, digit
// shifter and the response output register. Depends on int2a_pkg, int2a_rsp_if.
module int2a_datapath
   import int2a_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       req_value,
   input  logic [1:0]        req_operation,
   input  int2a_cmd_type     cmd,
   output int2a_status_type  status,
   int2a_rsp_if.source       rsp
);

   // Decimal digits of the widest word, hex digits, and the number of convert steps
   localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int DIG_BITS   = NUM_DIGITS * 4;
   localparam int SHIFT_BITS = ((VALUE_WIDTH + 3) / 4) * 4;
   localparam int STEPS      = SHIFT_BITS / 4;
   localparam int STEP_W     = $clog2(STEPS + 1);
   localparam int REM_W      = $clog2(NUM_DIGITS + 1);
   localparam int CNT_W      = ($clog2(NUM_DIGITS + 2) > 4) ? $clog2(NUM_DIGITS + 2) : 4;

   logic [VALUE_WIDTH-1:0] value_w;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   op_signed;
   logic                   op_hex;
   logic                   neg_load;

   logic [DIG_BITS-1:0]    digit_ff, digit_in;
   logic [SHIFT_BITS-1:0]  bin_ff, bin_in;
   logic [DIG_BITS-1:0]    dd_next;
   logic [SHIFT_BITS-1:0]  bb_next;
   logic                   neg_ff, neg_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]       cnt_next;
   logic [3:0]             top_digit;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             char_ff, char_in;
   logic                   last_ff, last_in;
   logic [3:0]             count_ff, count_in;

   // Take the low VALUE_WIDTH bits of the request word, zero-extended if wider than 32
   generate
      if (VALUE_WIDTH <= 32) begin : g_narrow
         assign value_w = req_value[VALUE_WIDTH-1:0];
      end else begin : g_wide
         assign value_w = {{(VALUE_WIDTH-32){1'b0}}, req_value};
      end
   endgenerate

   // Decode the format code
   always_comb begin
      op_signed = 1'b0;
      op_hex    = 1'b0;
      unique case (req_operation)
         OP_SIGNED_DEC:   op_signed = 1'b1;
         OP_UNSIGNED_DEC: op_signed = 1'b0;
         OP_SIGNED_HEX: begin
            op_signed = 1'b1;
            op_hex    = 1'b1;
         end
         OP_UNSIGNED_HEX: op_hex = 1'b1;
         default:         op_hex = 1'b0;
      endcase
   end

   // Negate negative signed words; the most negative value stays as its bits
   assign neg_load  = op_signed && value_w[VALUE_WIDTH-1];
   assign magnitude = neg_load ? (~value_w + 1'b1) : value_w;

   // Four shift-add-3 steps per cycle
   always_comb begin
      dd_next = digit_ff;
      bb_next = bin_ff;
      for (int s = 0; s < 4; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (dd_next[d*4 +: 4] >= 4'd5) begin
               dd_next[d*4 +: 4] = dd_next[d*4 +: 4] + 4'd3;
            end
         end
         dd_next = {dd_next[DIG_BITS-2:0], bb_next[SHIFT_BITS-1]};
         bb_next = {bb_next[SHIFT_BITS-2:0], 1'b0};
      end
   end

   assign top_digit = digit_ff[DIG_BITS-1 -: 4];
   assign cnt_next  = cnt_ff + CNT_W'(1);

   // Next values of the working registers
   always_comb begin
      digit_in = digit_ff;
      bin_in   = bin_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         neg_in  = neg_load;
         rem_in  = REM_W'(NUM_DIGITS);
         step_in = STEP_W'(STEPS);
         cnt_in  = '0;
         bin_in  = {{(SHIFT_BITS-VALUE_WIDTH){1'b0}}, magnitude};
         if (op_hex) begin
            digit_in = {{(DIG_BITS-VALUE_WIDTH){1'b0}}, magnitude};
         end else begin
            digit_in = '0;
         end
      end else if (cmd.convert) begin
         digit_in = dd_next;
         bin_in   = bb_next;
         step_in  = step_ff - STEP_W'(1);
      end else if (cmd.emit_sign) begin
         cnt_in = cnt_next;
      end else if (cmd.skip_shift || cmd.emit_digit) begin
         digit_in = {digit_ff[DIG_BITS-5:0], 4'd0};
         rem_in   = rem_ff - REM_W'(1);
         if (cmd.emit_digit) begin
            cnt_in = cnt_next;
         end
      end
   end

   // Next values of the response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      if (cmd.emit_sign) begin
         rsp_valid_in = 1'b1;
         char_in      = CHAR_MINUS;
         last_in      = 1'b0;
         count_in     = 4'd0;
      end else if (cmd.emit_digit) begin
         rsp_valid_in = 1'b1;
         char_in      = digit_to_ascii(top_digit);
         last_in      = (rem_ff == REM_W'(1));
         count_in     = last_in ? cnt_next[3:0] : 4'd0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      bin_ff   <= bin_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      cnt_ff   <= cnt_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      count_ff <= count_in;
   end

   assign status.load_hex  = op_hex;
   assign status.load_neg  = neg_load;
   assign status.neg       = neg_ff;
   assign status.top_zero  = (top_digit == 4'd0);
   assign status.rem_one   = (rem_ff == REM_W'(1));
   assign status.step_last = (step_ff == STEP_W'(1));
   assign status.slot_free = !rsp_valid_ff || rsp.ready;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.character  = char_ff;
   assign rsp.last       = last_ff;
   assign rsp.char_count = count_ff;

endmodule

/* sv/integer_to_ascii_digits_core.sv */
// Prints one word per request as ASCII, one character per response, most
// significant digit first with no leading zeros; signed modes lead a negative
// value with '-', in hex too. Decimal requests run the shift-add-3 BCD
// converter at four bits per cycle; hex requests skip it. An optional sign
// state follows, then the digit shifter drops the leading zero digits and
// the characters are emitted while the response side is ready.
// The next request is taken as soon as the last character sits in the output
// register, even if it is not yet taken.
// Depends on int2a_pkg, int2a_req_if, int2a_rsp_if, int2a_ctrl, int2a_datapath.
module integer_to_ascii_digits_core
   import int2a_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
)
(
   input  logic         clock,
   input  logic         reset,
   int2a_req_if.sink    req_bus,
   int2a_rsp_if.source  rsp_bus
);

   int2a_cmd_type    cmd;
   int2a_status_type status;

   // Sequence the request
   int2a_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Convert and emit characters
   int2a_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_bus.value),
      .req_operation (req_bus.operation),
      .cmd           (cmd),
      .status        (status),
      .rsp           (rsp_bus)
   );

endmodule

/* sv/int2a_checker.sv */
// Port-level checks for the converter, attached to the top level by bind.
// Depends on int2a_pkg and integer_to_ascii_digits_core.
module int2a_checker
   import int2a_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_character,
   input logic       rsp_last,
   input logic [3:0] rsp_char_count
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character)
         && $stable(rsp_last) && $stable(rsp_char_count))
      else $error("stalled response changed");

   // Drop ready once a request is taken
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after a request");

   // Count only on the final character
   a_count_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_char_count == 4'd0)
      else $error("count on a non-final character");

   // Never end a number on the sign
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == CHAR_MINUS |-> !rsp_last)
      else $error("number ended on a sign");

   // Emit only sign, decimal digits or lower-case hex digits
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == CHAR_MINUS)
         || (rsp_character >= CHAR_ZERO && rsp_character <= CHAR_NINE)
         || (rsp_character >= CHAR_LOW_A && rsp_character <= CHAR_LOW_F))
      else $error("illegal character");

endmodule

bind integer_to_ascii_digits_core int2a_checker u_int2a_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_character  (rsp_bus.character),
   .rsp_last       (rsp_bus.last),
   .rsp_char_count (rsp_bus.char_count)
);

/* tb/testbench.sv */
// Self-checking bench for integer_to_ascii_digits_core: a table of requests,
// then random ones, each checked character by character against the table text or a local model.
// Depends on int2a_pkg, int2a_req_if, int2a_rsp_if and the core.
module testbench;
   import int2a_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_COUNT  = 480;
   localparam int TABLE_ROWS    = 22;
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_PERCENT  = 29;
   localparam int SHOW_LIMIT    = 10;

   // Digit glyphs, most significant byte is digit 0
   localparam logic [8*16-1:0] DIGIT_GLYPHS = "0123456789abcdef";

   typedef struct packed {
      logic [7:0] character;
      logic       last;
      logic [3:0] char_count;
   } digit_char_type;

   typedef logic [7:0] char_list_type [$];

   // One table row; a zero text means the local model supplies the expectation
   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  operation;
      logic [87:0] text;
   } table_row_type;

   logic clock;
   logic reset;
   logic steady_window;

   int2a_req_if req_bus ();
   int2a_rsp_if rsp_bus ();

   digit_char_type pending_chars [$];
   table_row_type  stimulus_table [TABLE_ROWS];

   int cycle_count;
   int error_count;
   int chars_checked;
   int requests_sent;
   int negatives_sent;
   int format_seen [4];

   integer_to_ascii_digits_core #(
      .VALUE_WIDTH(32)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   // Clock generator
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Spell one word in the given format, most significant character first
   function automatic char_list_type spell_number(input logic [31:0] value,
                                                  input logic [1:0]  operation);
      char_list_type text;
      logic [31:0]   magnitude;
      logic [31:0]   radix;
      logic          negative;
      radix = (operation == OP_SIGNED_HEX || operation == OP_UNSIGNED_HEX) ? 32'd16 : 32'd10;
      negative = (operation == OP_SIGNED_DEC || operation == OP_SIGNED_HEX) && value[31];
      magnitude = negative ? 32'd0 - value : value;
      do begin
         text.push_front(DIGIT_GLYPHS[8 * (15 - magnitude % radix) +: 8]);
         magnitude = magnitude / radix;
      end while (magnitude != 32'd0);
      if (negative) begin
         text.push_front(CHAR_MINUS);
      end
      return text;
   endfunction

   // Unpack a right-justified table text, dropping the zero padding
   function automatic char_list_type unpack_text(input logic [87:0] packed_text);
      char_list_type text;
      for (int i = 10; i >= 0; i--) begin
         if (packed_text[8 * i +: 8] != 8'd0) begin
            text.push_back(packed_text[8 * i +: 8]);
         end
      end
      return text;
   endfunction

   // Queue the characters of one number; only the final one carries last and count
   function automatic void expect_text(input char_list_type text);
      digit_char_type item;
      for (int k = 0; k < text.size(); k++) begin
         item.character  = text[k];
         item.last       = (k == text.size() - 1);
         item.char_count = item.last ? 4'(text.size()) : 4'd0;
         pending_chars.push_back(item);
      end
   endfunction

   // Pick a value that leans on digit-count edges, signs and extremes
   function automatic logic [31:0] pick_value();
      logic [31:0] value;
      logic [31:0] power;
      case ($urandom_range(0, 6))
         0, 1: value = $urandom;
         2: value = $urandom_range(0, 99);
         3: value = 32'd0 - $urandom_range(1, 99);
         4: value = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
         5: value = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_fffc)
                    + $urandom_range(0, 3);
         default: begin
            power = 32'd1;
            repeat ($urandom_range(0, 9)) power = power * 32'd10;
            value = power - $urandom_range(0, 1);
         end
      endcase
      return value;
   endfunction

   task automatic log_fault(input string message);
      error_count++;
      if (error_count <= SHOW_LIMIT) begin
         $display("[%0d] %s", cycle_count, message);
      end
   endtask

   // Send one request at the falling edge and queue its characters on acceptance
   task automatic send_request(input logic [31:0] value, input logic [1:0] operation,
                               input char_list_type text, input bit allow_gaps);
      while (allow_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.value     <= value;
      req_bus.operation <= operation;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expect_text(text);
      requests_sent++;
      format_seen[operation]++;
      if ((operation == OP_SIGNED_DEC || operation == OP_SIGNED_HEX) && value[31]) begin
         negatives_sent++;
      end
      @(negedge clock);
   endtask

   // Hold off new requests until every queued character has come back
   task automatic drain_pending();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_chars.size() != 0);
   endtask

   // Response side: stall at random outside the steady window
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && (steady_window || $urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Check each accepted character against the oldest expectation
   always @(posedge clock) begin
      digit_char_type wanted;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         chars_checked++;
         if (pending_chars.size() == 0) begin
            log_fault($sformatf("unexpected character %h last %b count %0d",
                                rsp_bus.character, rsp_bus.last, rsp_bus.char_count));
         end else begin
            wanted = pending_chars.pop_front();
            if (rsp_bus.character != wanted.character || rsp_bus.last != wanted.last ||
                rsp_bus.char_count != wanted.char_count) begin
               log_fault($sformatf("expected %h/%b/%0d, got %h/%b/%0d",
                                   wanted.character, wanted.last, wanted.char_count,
                                   rsp_bus.character, rsp_bus.last, rsp_bus.char_count));
            end
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      logic [31:0]   value;
      logic [1:0]    operation;
      char_list_type expected;
      reset             = 1'b1;
      steady_window     = 1'b0;
      req_bus.valid     = 1'b0;
      req_bus.value     = 32'd0;
      req_bus.operation = OP_SIGNED_DEC;
      rsp_bus.ready     = 1'b0;
      cycle_count       = 0;
      error_count       = 0;
      chars_checked     = 0;
      requests_sent     = 0;
      negatives_sent    = 0;
      format_seen       = '{0, 0, 0, 0};

      stimulus_table = '{
         '{32'h0000_0000, OP_SIGNED_DEC,   88'("0")},
         '{32'h0000_0000, OP_UNSIGNED_DEC, 88'("0")},
         '{32'h0000_0000, OP_SIGNED_HEX,   88'("0")},
         '{32'h0000_0000, OP_UNSIGNED_HEX, 88'("0")},
         '{32'hffff_ffff, OP_SIGNED_DEC,   88'("-1")},
         '{32'hffff_ffff, OP_UNSIGNED_DEC, 88'("4294967295")},
         '{32'hffff_ffff, OP_SIGNED_HEX,   88'("-1")},
         '{32'hffff_ffff, OP_UNSIGNED_HEX, 88'("ffffffff")},
         '{32'h8000_0000, OP_SIGNED_DEC,   88'("-2147483648")},
         '{32'h8000_0000, OP_UNSIGNED_DEC, 88'("2147483648")},
         '{32'h8000_0000, OP_SIGNED_HEX,   88'("-80000000")},
         '{32'h8000_0000, OP_UNSIGNED_HEX, 88'("80000000")},
         '{32'h7fff_ffff, OP_SIGNED_DEC,   88'("2147483647")},
         '{32'h7fff_ffff, OP_SIGNED_HEX,   88'("7fffffff")},
         '{32'h0000_0001, OP_SIGNED_DEC,   88'd0},
         '{32'h0000_0001, OP_UNSIGNED_HEX, 88'd0},
         '{32'h0000_000a, OP_UNSIGNED_DEC, 88'd0},
         '{32'h0000_000f, OP_SIGNED_HEX,   88'd0},
         '{32'h3b9a_ca00, OP_UNSIGNED_DEC, 88'd0},
         '{32'habcd_ef01, OP_UNSIGNED_HEX, 88'd0},
         '{32'hdead_beef, OP_SIGNED_HEX,   88'd0},
         '{32'h1234_5678, OP_SIGNED_DEC,   88'd0}
      };

      // Hold reset, release at a falling edge
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the table, back to back with random gaps
      foreach (stimulus_table[i]) begin
         if (stimulus_table[i].text != 88'd0) begin
            expected = unpack_text(stimulus_table[i].text);
         end else begin
            expected = spell_number(stimulus_table[i].value, stimulus_table[i].operation);
         end
         send_request(stimulus_table[i].value, stimulus_table[i].operation, expected, 1'b1);
      end

      // Random requests; a middle stretch runs with no idling on either side
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i == 100 || i == 350) begin
            drain_pending();
         end
         steady_window <= (i >= 200 && i < 300);
         value     = pick_value();
         operation = 2'($urandom_range(0, 3));
         send_request(value, operation, spell_number(value, operation),
                      !(i >= 200 && i < 300));
      end
      req_bus.valid <= 1'b0;
      steady_window <= 1'b0;

      // Drain, then watch for stray characters
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d requests (%0d from the table), %0d characters checked",
               requests_sent, TABLE_ROWS, chars_checked);
      $display("formats sdec %0d udec %0d shex %0d uhex %0d, %0d negative signed values",
               format_seen[0], format_seen[1], format_seen[2], format_seen[3],
               negatives_sent);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("mismatches: %0d", error_count);
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/int2a_pkg.sv
sv/int2a_req_if.sv
sv/int2a_rsp_if.sv
sv/int2a_ctrl.sv
sv/int2a_datapath.sv
sv/integer_to_ascii_digits_core.sv
sv/int2a_checker.sv
tb/testbench.sv
